// ----- rtl/avc_pkg.sv -----
// Shared constants and types for the autokey Vigenere cipher block.
`timescale 1ns / 1ps
package avc_pkg;

    localparam int MAX_KEY_LETTERS = 12;
    localparam int LETTER_W        = 5;
    localparam int KEY_W           = MAX_KEY_LETTERS * LETTER_W;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [LETTER_W-1:0] ALPHABET_SIZE = LETTER_W'(26);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = CFG_IDX_W'(2);

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                start;
        logic                bad;
    } t_item;

    typedef struct packed {
        logic [KEY_W-1:0] key_letters;
        logic [LEN_W-1:0] key_length;
        logic             decrypt_mode;
    } t_cfg;

endpackage

// ----- rtl/avc_front.sv -----
// Front end: accept and classify letters, hold them in a two-entry queue.
`timescale 1ns / 1ps
module avc_front
    import avc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_message_start,
    output logic                o_q_valid,
    output t_item               o_q_item,
    input  logic                i_q_pop
);

    t_item       r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        w_push;
    logic        w_pop;
    t_item       w_item;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_comb begin
        w_item.letter = i_letter;
        w_item.start  = i_message_start;
        w_item.bad    = (i_letter >= ALPHABET_SIZE);
        n_count       = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

endmodule

// ----- rtl/avc_back.sv -----
// Back end: keystream delay line, modulo shift and output register.
`timescale 1ns / 1ps
module avc_back
    import avc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LETTER_W-1:0] o_cipher_letter,
    output logic                o_bad_letter
);

    logic [LETTER_W-1:0] r_line [MAX_KEY_LETTERS];
    logic [LETTER_W-1:0] n_line [MAX_KEY_LETTERS];
    logic [LETTER_W-1:0] w_base [MAX_KEY_LETTERS];
    logic                r_out_valid;
    logic [LETTER_W-1:0] r_cipher;
    logic                r_bad;
    logic                w_take;
    logic [LEN_W-1:0]    w_len;
    logic [LEN_W-1:0]    w_last;
    logic [LETTER_W-1:0] w_shift;
    logic [LETTER_W:0]   w_sum;
    logic [LETTER_W-1:0] w_result;
    logic [LETTER_W-1:0] w_plain;

    assign w_take  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = w_take;

    always_comb begin
        if (i_cfg.key_length == LEN_W'(0)) begin
            w_len = LEN_W'(1);
        end else if (i_cfg.key_length > LEN_W'(MAX_KEY_LETTERS)) begin
            w_len = LEN_W'(MAX_KEY_LETTERS);
        end else begin
            w_len = i_cfg.key_length;
        end
        w_last = w_len - LEN_W'(1);

        for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
            if (i_q_item.start && (LEN_W'(i) < w_len)) begin
                w_base[i] = i_cfg.key_letters[LETTER_W*i +: LETTER_W];
            end else begin
                w_base[i] = r_line[i];
            end
        end

        w_shift = (w_base[0] >= ALPHABET_SIZE) ? '0 : w_base[0];

        if (i_cfg.decrypt_mode) begin
            w_sum = {1'b0, i_q_item.letter} + {1'b0, ALPHABET_SIZE} - {1'b0, w_shift};
        end else begin
            w_sum = {1'b0, i_q_item.letter} + {1'b0, w_shift};
        end
        if (w_sum >= {1'b0, ALPHABET_SIZE}) begin
            w_sum = w_sum - {1'b0, ALPHABET_SIZE};
        end

        if (i_q_item.bad) begin
            w_result = i_q_item.letter;
            w_plain  = i_q_item.letter;
        end else begin
            w_result = w_sum[LETTER_W-1:0];
            w_plain  = i_cfg.decrypt_mode ? w_sum[LETTER_W-1:0] : i_q_item.letter;
        end

        for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
            n_line[i] = w_base[i];
            if (LEN_W'(i) == w_last) begin
                n_line[i] = w_plain;
            end else if (i < MAX_KEY_LETTERS - 1) begin
                if (LEN_W'(i) < w_last) begin
                    n_line[i] = w_base[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_line      <= n_line;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cipher <= w_result;
            r_bad    <= i_q_item.bad;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_cipher;
    assign o_bad_letter    = r_bad;

endmodule

// ----- rtl/autokey_vigenere_cipher_top.sv -----
// Top level of the autokey Vigenere cipher: configuration registers and wiring.
//
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid/o_in_ready    i_letter, i_message_start
// out       output     o_out_valid/i_out_ready  o_cipher_letter, o_bad_letter
// cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One letter per cycle sustained while the output is not stalled; an accepted letter
// is written into the queue, and the back end pops it once its output register is free
// and registers the result there, raising o_out_valid.
// The keystream update is a loop through the r_line register in the back end.
// Synchronous active-low reset clears the queue, output valid, keystream line
// and config registers. A stalled output fills the two-entry queue, then drops o_in_ready.
`timescale 1ns / 1ps
module autokey_vigenere_cipher_top
    import avc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [LETTER_W-1:0]  i_letter,
    input  logic                 i_message_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LETTER_W-1:0]  o_cipher_letter,
    output logic                 o_bad_letter,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_letters  <= '0;
            r_cfg.key_length   <= LEN_W'(1);
            r_cfg.decrypt_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_LETTERS:  r_cfg.key_letters  <= i_cfg_data;
                CFG_KEY_LENGTH:   r_cfg.key_length   <= i_cfg_data[LEN_W-1:0];
                CFG_DECRYPT_MODE: r_cfg.decrypt_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    avc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_letter        (i_letter),
        .i_message_start (i_message_start),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    avc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_bad_letter    (o_bad_letter)
    );

`ifndef NO_ASSERTIONS
    a_bad_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_letter |-> o_cipher_letter >= ALPHABET_SIZE)
        else $error("flagged letter inside alphabet");

    a_good_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_letter |-> o_cipher_letter < ALPHABET_SIZE)
        else $error("transformed letter outside alphabet");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");
`endif

endmodule

// ----- tb/autokey_vigenere_cipher_top_tb.sv -----
// Self-checking testbench for the autokey Vigenere cipher top level.
`timescale 1ns / 1ps
module autokey_vigenere_cipher_top_tb;
    import avc_pkg::*;

    localparam int ALPHA_LEN   = ALPHABET_SIZE;
    localparam int LONG_STALL  = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                start;
    } t_plain_item;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                bad;
    } t_cipher_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [LETTER_W-1:0]  letter = '0;
    logic                 msg_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LETTER_W-1:0]  cipher_letter;
    logic                 bad_letter;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data = '0;

    t_plain_item    letters_to_send[$];
    t_cipher_result expected_ciphers[$];

    logic [KEY_W-1:0]    key_shadow;
    logic [LEN_W-1:0]    len_shadow;
    logic                decrypt_shadow;
    logic [LETTER_W-1:0] keystream[MAX_KEY_LETTERS];

    int send_gap_max = 10;
    int recv_gap_max = 10;
    int send_wait = 0;
    int recv_wait = 0;
    int long_stalls_asked = 0;
    int long_stalls_taken = 0;
    int stall_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    autokey_vigenere_cipher_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_letter        (letter),
        .i_message_start (msg_start),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_cipher_letter (cipher_letter),
        .o_bad_letter    (bad_letter),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic t_cipher_result encipher_letter(input t_plain_item item);
        t_cipher_result res;
        int len;
        int shift;
        int code;
        int plain;
        int i;
        if (len_shadow == 0) len = 1;
        else if (len_shadow > MAX_KEY_LETTERS) len = MAX_KEY_LETTERS;
        else len = len_shadow;
        if (item.start) begin
            for (i = 0; i < len; i++) keystream[i] = key_shadow[LETTER_W*i +: LETTER_W];
        end
        shift = keystream[0];
        if (shift >= ALPHA_LEN) shift = 0;
        code = item.letter;
        res.bad = (code >= ALPHA_LEN);
        if (res.bad) begin
            res.letter = item.letter;
            plain = code;
        end else if (decrypt_shadow) begin
            res.letter = LETTER_W'((code + ALPHA_LEN - shift) % ALPHA_LEN);
            plain = res.letter;
        end else begin
            res.letter = LETTER_W'((code + shift) % ALPHA_LEN);
            plain = code;
        end
        for (i = 0; i + 1 < len; i++) keystream[i] = keystream[i+1];
        keystream[len-1] = LETTER_W'(plain);
        return res;
    endfunction

    // Input driver: hold the transaction until accepted, then wait the drawn gap.
    always @(posedge clk) begin : driver
        t_plain_item item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end else if (in_valid && !in_ready) begin
            in_valid <= 1'b1;
        end else if (send_wait != 0) begin
            send_wait <= send_wait - 1;
            in_valid <= 1'b0;
        end else if (letters_to_send.size() != 0) begin
            item = letters_to_send.pop_front();
            letter <= item.letter;
            msg_start <= item.start;
            in_valid <= 1'b1;
            send_wait <= $urandom_range(0, send_gap_max);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Output receiver: random stall per transaction, plus long hold-offs on request.
    always @(posedge clk) begin : receiver
        int w;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (long_stalls_taken != long_stalls_asked) begin
            long_stalls_taken <= long_stalls_taken + 1;
            stall_left <= LONG_STALL;
            out_ready <= 1'b0;
        end else if (out_ready && out_valid) begin
            w = $urandom_range(0, recv_gap_max);
            if (w == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                recv_wait <= w - 1;
            end
        end else if (!out_ready) begin
            if (recv_wait != 0) recv_wait <= recv_wait - 1;
            else out_ready <= 1'b1;
        end
    end

    // Monitor: track configuration, predict accepted letters, check results.
    always @(posedge clk) begin : monitor
        t_plain_item    item;
        t_cipher_result want;
        int i;
        if (!rst_n) begin
            key_shadow = '0;
            len_shadow = LEN_W'(1);
            decrypt_shadow = 1'b0;
            for (i = 0; i < MAX_KEY_LETTERS; i++) keystream[i] = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KEY_LETTERS:  key_shadow = cfg_data;
                    CFG_KEY_LENGTH:   len_shadow = cfg_data[LEN_W-1:0];
                    CFG_DECRYPT_MODE: decrypt_shadow = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                item.letter = letter;
                item.start = msg_start;
                expected_ciphers.push_back(encipher_letter(item));
            end
            if (out_valid && out_ready) begin
                if (expected_ciphers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result letter %0d bad %0d",
                                              cipher_letter, bad_letter));
                end else begin
                    want = expected_ciphers.pop_front();
                    if (cipher_letter !== want.letter)
                        report_mismatch($sformatf("cipher_letter expected %0d got %0d",
                                                  want.letter, cipher_letter));
                    if (bad_letter !== want.bad)
                        report_mismatch($sformatf("bad_letter expected %0d got %0d",
                                                  want.bad, bad_letter));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic settle();
        do @(negedge clk);
        while (letters_to_send.size() != 0 || in_valid || expected_ciphers.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [KEY_W-1:0] key, input int len, input bit dec);
        write_reg(CFG_KEY_LETTERS, key);
        write_reg(CFG_KEY_LENGTH, KEY_W'(len));
        write_reg(CFG_DECRYPT_MODE, KEY_W'(dec));
        @(negedge clk);
    endtask

    task automatic push_item(input int code, input bit start);
        t_plain_item item;
        item.letter = LETTER_W'(code);
        item.start = start;
        letters_to_send.push_back(item);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] key;
        int i;
        for (i = 0; i < MAX_KEY_LETTERS; i++) begin
            if ($urandom_range(0, 5) == 0)
                key[LETTER_W*i +: LETTER_W] = LETTER_W'($urandom_range(26, 31));
            else
                key[LETTER_W*i +: LETTER_W] = LETTER_W'($urandom_range(0, 25));
        end
        return key;
    endfunction

    task automatic queue_messages(input int count);
        int n;
        int len;
        int i;
        bit start;
        n = 0;
        while (n < count) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
            for (i = 0; i < len; i++) begin
                if (i == 0) start = ($urandom_range(0, 7) != 0);
                else start = ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 9) == 0) push_item($urandom_range(26, 31), start);
                else push_item($urandom_range(0, 25), start);
            end
            n += len;
        end
    endtask

    initial begin : stimulus
        int phase;
        int len;
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_item(0, 0);
        push_item(25, 0);
        push_item(26, 0);
        push_item(31, 0);
        push_item(13, 1);
        push_item(7, 0);
        configure(KEY_W'({5'd26, 5'd31, 5'd25, 5'd3}), 4, 0);
        push_item(25, 1);
        push_item(0, 0);
        push_item(24, 0);
        push_item(30, 0);
        push_item(5, 0);
        push_item(1, 0);
        write_reg(CFG_DECRYPT_MODE, KEY_W'(1));
        @(negedge clk);
        push_item(2, 1);
        push_item(25, 0);
        push_item(0, 0);
        push_item(27, 0);
        push_item(9, 0);
        configure(random_key(), 13, 1);
        repeat (4) push_item($urandom_range(0, 25), 1'b0 | (letters_to_send.size() == 0));
        write_reg(CFG_KEY_LENGTH, KEY_W'(0));
        @(negedge clk);
        repeat (3) push_item($urandom_range(0, 31), 0);
        write_reg(CFG_KEY_LENGTH, KEY_W'(15));
        @(negedge clk);
        repeat (3) push_item($urandom_range(0, 31), 0);

        for (phase = 0; phase < 8; phase++) begin
            pick = $urandom_range(0, 9);
            if (phase == 0) len = 1;
            else if (phase == 1) len = 12;
            else if (pick == 0) len = 0;
            else if (pick == 1) len = $urandom_range(13, 15);
            else len = $urandom_range(1, 12);
            configure(random_key(), len, (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            send_gap_max = (phase % 3 == 0) ? 0 : 10;
            recv_gap_max = (phase % 4 == 1) ? 0 : 10;
            if (phase == 3) begin
                queue_messages(PHASE_ITEMS / 2);
                settle();
                @(negedge clk);
                queue_messages(PHASE_ITEMS / 2);
            end else begin
                queue_messages(PHASE_ITEMS);
                if (phase == 2 || phase == 5) long_stalls_asked++;
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (expected_ciphers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_ciphers.size()));
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/avc_pkg.sv
rtl/avc_front.sv
rtl/avc_back.sv
rtl/autokey_vigenere_cipher_top.sv
tb/autokey_vigenere_cipher_top_tb.sv
